FILE: src/ntbc_pkg.sv
// Shared constants, types and helper functions for the NAND timing to bus cycle converter.
package ntbc_pkg;

  // Width of a stored timing value in picoseconds.
  localparam int TIME_WIDTH = 20;

  // Port field widths.
  localparam int CP_W           = 10;
  localparam int IDX_W          = 5;
  localparam int TIMING_VALUE_W = 20;
  localparam int FIELD_CODE_W   = 4;
  localparam int ENC_W          = 9;
  localparam int STATUS_W       = 2;
  localparam int TDF_W          = 4;

  // The clock period in picoseconds is at most 1023 * 1000, which fits in 20 bits.
  localparam int PER_W = 20;
  // Dividend of the rounded-up division: timing plus period minus one.
  localparam int DIV_W = ((TIME_WIDTH > PER_W) ? TIME_WIDTH : PER_W) + 1;
  // The period is at least 1000 ps, so a count stays below 2^(TIME_WIDTH-9).
  localparam int CNT_W = TIME_WIDTH - 9;
  // Room for the sum of three counts.
  localparam int SUM_W = CNT_W + 2;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int NUM_TIMINGS = 21;
  localparam int NUM_STEPS   = 21;
  localparam int NUM_GROUPS  = 13;
  localparam int STEP_W      = $clog2(NUM_STEPS);
  localparam int GRP_W       = $clog2(NUM_GROUPS);

  localparam int unsigned EDO_LIMIT_PS = 30000;
  localparam int unsigned PS_PER_NS    = 1000;
  localparam int unsigned TDF_MAX      = 15;
  localparam logic [CP_W-1:0] CP_RESET = CP_W'(8);

  // Timing slots in load order.
  localparam int T_WP   = 0;
  localparam int T_CLS  = 1;
  localparam int T_CS   = 2;
  localparam int T_ALS  = 3;
  localparam int T_DS   = 4;
  localparam int T_CLH  = 5;
  localparam int T_CH   = 6;
  localparam int T_ALH  = 7;
  localparam int T_DH   = 8;
  localparam int T_WH   = 9;
  localparam int T_WC   = 10;
  localparam int T_REH  = 11;
  localparam int T_RHOH = 12;
  localparam int T_RHZ  = 13;
  localparam int T_RP   = 14;
  localparam int T_RC   = 15;
  localparam int T_CLR  = 16;
  localparam int T_ADL  = 17;
  localparam int T_AR   = 18;
  localparam int T_RR   = 19;
  localparam int T_WB   = 20;

  // Division groups: each is the maximum of one or more timings, rounded up to cycles.
  localparam int G_WPULSE = 0;
  localparam int G_WSETUP = 1;
  localparam int G_WHOLD  = 2;
  localparam int G_WC     = 3;
  localparam int G_RHOLD  = 4;
  localparam int G_RHZ    = 5;
  localparam int G_RPULSE = 6;
  localparam int G_RC     = 7;
  localparam int G_CLR    = 8;
  localparam int G_ADL    = 9;
  localparam int G_AR     = 10;
  localparam int G_RR     = 11;
  localparam int G_WB     = 12;

  // Commands.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EDO     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHECKED = 2'd2;

  // Result field codes.
  localparam logic [FIELD_CODE_W-1:0] F_NWE_SETUP = 4'd0;
  localparam logic [FIELD_CODE_W-1:0] F_NWE_PULSE = 4'd1;
  localparam logic [FIELD_CODE_W-1:0] F_NWE_CYCLE = 4'd2;
  localparam logic [FIELD_CODE_W-1:0] F_NCS_WR    = 4'd3;
  localparam logic [FIELD_CODE_W-1:0] F_NRD_PULSE = 4'd4;
  localparam logic [FIELD_CODE_W-1:0] F_NRD_CYCLE = 4'd5;
  localparam logic [FIELD_CODE_W-1:0] F_NCS_RD    = 4'd6;
  localparam logic [FIELD_CODE_W-1:0] F_TDF       = 4'd7;
  localparam logic [FIELD_CODE_W-1:0] F_TCLR      = 4'd8;
  localparam logic [FIELD_CODE_W-1:0] F_TADL      = 4'd9;
  localparam logic [FIELD_CODE_W-1:0] F_TAR       = 4'd10;
  localparam logic [FIELD_CODE_W-1:0] F_TRR       = 4'd11;
  localparam logic [FIELD_CODE_W-1:0] F_TWB       = 4'd12;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    count_t quotient;
  } div_rsp_t;

  // Timing slot read at each accumulation step.
  function automatic logic [IDX_W-1:0] step_timing(logic [STEP_W-1:0] step);
    logic [IDX_W-1:0] idx;
    unique case (step)
      5'd0:    idx = IDX_W'(T_WP);
      5'd1:    idx = IDX_W'(T_CLS);
      5'd2:    idx = IDX_W'(T_CS);
      5'd3:    idx = IDX_W'(T_ALS);
      5'd4:    idx = IDX_W'(T_DS);
      5'd5:    idx = IDX_W'(T_CLH);
      5'd6:    idx = IDX_W'(T_CH);
      5'd7:    idx = IDX_W'(T_ALH);
      5'd8:    idx = IDX_W'(T_DH);
      5'd9:    idx = IDX_W'(T_WH);
      5'd10:   idx = IDX_W'(T_WC);
      5'd11:   idx = IDX_W'(T_REH);
      5'd12:   idx = IDX_W'(T_RHOH);
      5'd13:   idx = IDX_W'(T_RHZ);
      5'd14:   idx = IDX_W'(T_RP);
      5'd15:   idx = IDX_W'(T_RC);
      5'd16:   idx = IDX_W'(T_CLR);
      5'd17:   idx = IDX_W'(T_ADL);
      5'd18:   idx = IDX_W'(T_AR);
      5'd19:   idx = IDX_W'(T_RR);
      5'd20:   idx = IDX_W'(T_WB);
      default: idx = IDX_W'(T_WP);
    endcase
    return idx;
  endfunction

  // True on the last step of a division group.
  function automatic logic step_ends_group(logic [STEP_W-1:0] step);
    logic ends;
    case (step) inside
      5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8, 5'd11: ends = 1'b0;
      default:                                         ends = 1'b1;
    endcase
    return ends;
  endfunction

  // Split msb/lsb encoding with saturation; the msb weight is 2^fshift.
  function automatic logic [ENC_W-1:0] encode_count(sum_t n, int unsigned pos,
                                                    int unsigned width,
                                                    int unsigned fshift);
    sum_t lmask;
    sum_t mmask;
    sum_t msb;
    sum_t lsb;
    lmask = (SUM_W'(1) << pos) - SUM_W'(1);
    mmask = (SUM_W'(1) << width) - SUM_W'(1);
    msb   = n >> fshift;
    lsb   = n & ((SUM_W'(1) << fshift) - SUM_W'(1));
    if (lsb > lmask) begin
      lsb = '0;
      msb = msb + SUM_W'(1);
    end
    if (msb > mmask) begin
      msb = mmask;
      lsb = lmask;
    end
    return ENC_W'((msb << pos) | lsb);
  endfunction

  function automatic logic [ENC_W-1:0] enc_setup(sum_t n);
    return encode_count(n, 5, 1, 7);
  endfunction

  function automatic logic [ENC_W-1:0] enc_pulse(sum_t n);
    return encode_count(n, 6, 1, 8);
  endfunction

  function automatic logic [ENC_W-1:0] enc_cycle(sum_t n);
    return encode_count(n, 7, 2, 8);
  endfunction

  function automatic logic [ENC_W-1:0] enc_timing(sum_t n);
    return encode_count(n, 3, 1, 6);
  endfunction

endpackage

FILE: src/ntbc_if.sv
// Valid/ready channel interfaces for the timing input and the encoded result output.
interface ntbc_in_if import ntbc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [IDX_W-1:0]          timing_index;
  logic [TIMING_VALUE_W-1:0] timing_value;
  logic                      check_only;

  modport source (output valid, cmd, timing_index, timing_value, check_only, input ready);
  modport sink   (input valid, cmd, timing_index, timing_value, check_only, output ready);
endinterface

interface ntbc_out_if import ntbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FIELD_CODE_W-1:0] field_code;
  logic [ENC_W-1:0]        encoded_value;
  logic [STATUS_W-1:0]     status;
  logic                    last;

  modport source (output valid, field_code, encoded_value, status, last, input ready);
  modport sink   (input valid, field_code, encoded_value, status, last, output ready);
endinterface

FILE: src/ntbc_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ntbc_div import ntbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [PER_W-1:0]     rem;
  logic [PER_W-1:0]     dvs;
  logic [DIV_W-1:0]     dvd;
  count_t               quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [PER_W:0]       trial;
  logic [PER_W:0]       trial_sub;
  logic                 fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial     = {rem, dvd[DIV_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        dvs  <= req.divisor;
        dvd  <= req.dividend;
        quo  <= '0;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        rem <= fits ? trial_sub[PER_W-1:0] : trial[PER_W-1:0];
        dvd <= {dvd[DIV_W-2:0], 1'b0};
        quo <= {quo[CNT_W-2:0], fits};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: src/nand_timing_to_bus_cycles.sv
// NAND SDR timing to static-memory bus cycle converter, top level.
// A load transaction (cmd 0) stores one timing value in picoseconds into one of 21 slots; an
// index above 20 is ignored. A compute transaction (cmd 1) first checks the stored read cycle
// time: below 30 ns one result with status 1 (EDO unsupported) is returned, otherwise with
// check_only set one result with status 2. A full compute returns 13 result transactions,
// field codes 0 to 12 in order, with last set on the final one. It steps through the 21 stored
// timings to take the maximum of each of the 13 groups; after each group the single shared
// divider rounds that maximum up to clock cycles at one quotient bit a cycle, and the finishing
// states S_FIN1 to S_FIN3 then derive the combined counts before the results are sent. The
// input is not ready while a compute is in progress. The clock period register is read as whole
// nanoseconds, a zero being taken as 1 ns, and should only be written while the block is idle.
module nand_timing_to_bus_cycles import ntbc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [CP_W-1:0] cfg_wr_data,
  ntbc_in_if.sink         item,
  ntbc_out_if.source      result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_LAUNCH,
    S_WAIT,
    S_FIN1,
    S_FIN2,
    S_FIN3,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration and timing store.
  logic [CP_W-1:0]       clock_period_ns;
  logic [CP_W-1:0]       cp_eff;
  logic [TIME_WIDTH-1:0] store [NUM_TIMINGS];
  logic [TIME_WIDTH-1:0] rd;
  logic                  rc_short;
  logic                  item_acc;

  // Sequencer registers.
  logic [PER_W-1:0]      period;
  logic [STEP_W-1:0]     step;
  logic [GRP_W-1:0]      grp;
  logic                  first;
  logic [TIME_WIDTH-1:0] acc;
  count_t                cyc [NUM_GROUPS];
  logic [STATUS_W-1:0]   mode;
  logic [FIELD_CODE_W-1:0] k;

  // Derived counts.
  sum_t             wsetup_r;
  sum_t             wsum_r;
  sum_t             wcycle_r;
  sum_t             rsum_r;
  sum_t             rcycle_r;
  logic [TDF_W-1:0] tdf_r;
  count_t           tdf_diff;
  logic [TDF_W-1:0] tdf_clamped;

  // Output register.
  logic                    out_valid;
  logic [FIELD_CODE_W-1:0] out_code;
  logic [ENC_W-1:0]        out_enc;
  logic [STATUS_W-1:0]     out_status;
  logic                    out_last;
  logic [ENC_W-1:0]        emit_enc;
  logic                    emit_last;
  logic                    out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ntbc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;

  // A zero period is taken as one nanosecond.
  assign cp_eff   = (clock_period_ns == '0) ? CP_W'(1) : clock_period_ns;
  assign rc_short = store[T_RC] < TIME_WIDTH'(EDO_LIMIT_PS);
  assign rd       = store[step_timing(step)];

  // The divider rounds up: it is given the group maximum plus the period less one.
  assign div_req.start    = (state == S_LAUNCH);
  assign div_req.dividend = DIV_W'(acc) + DIV_W'(period) - DIV_W'(1);
  assign div_req.divisor  = period;

  // TDF is the data float count after the read hold, clamped to the range 1 to 15.
  assign tdf_diff = (cyc[G_RHZ] > cyc[G_RHOLD]) ? (cyc[G_RHZ] - cyc[G_RHOLD]) : '0;
  always_comb begin
    if (tdf_diff > CNT_W'(TDF_MAX)) begin
      tdf_clamped = TDF_W'(TDF_MAX);
    end else if (tdf_diff == '0) begin
      tdf_clamped = TDF_W'(1);
    end else begin
      tdf_clamped = tdf_diff[TDF_W-1:0];
    end
  end

  // Select and encode the count for the field being sent.
  always_comb begin
    unique case (k)
      F_NWE_SETUP: emit_enc = enc_setup(wsetup_r);
      F_NWE_PULSE: emit_enc = enc_pulse(SUM_W'(cyc[G_WPULSE]));
      F_NWE_CYCLE: emit_enc = enc_cycle(wcycle_r);
      F_NCS_WR:    emit_enc = enc_pulse(wcycle_r);
      F_NRD_PULSE: emit_enc = enc_pulse(SUM_W'(cyc[G_RPULSE]));
      F_NRD_CYCLE: emit_enc = enc_cycle(rcycle_r);
      F_NCS_RD:    emit_enc = enc_pulse(rcycle_r);
      F_TDF:       emit_enc = ENC_W'(tdf_r);
      F_TCLR:      emit_enc = enc_timing(SUM_W'(cyc[G_CLR]));
      F_TADL:      emit_enc = enc_timing(SUM_W'(cyc[G_ADL]));
      F_TAR:       emit_enc = enc_timing(SUM_W'(cyc[G_AR]));
      F_TRR:       emit_enc = enc_timing(SUM_W'(cyc[G_RR]));
      F_TWB:       emit_enc = enc_timing(SUM_W'(cyc[G_WB]));
      default:     emit_enc = '0;
    endcase
  end

  assign emit_last = (mode != ST_VALID) || (k == F_TWB);
  assign out_free  = !out_valid || result.ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_period_ns <= CP_RESET;
    end else if (cfg_wr_en) begin
      clock_period_ns <= cfg_wr_data;
    end
  end

  // Timing store; slots above the last timing are not written.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMINGS; i++) begin
        store[i] <= '0;
      end
    end else if (item_acc && item.cmd == CMD_LOAD &&
                 item.timing_index < IDX_W'(NUM_TIMINGS)) begin
      store[item.timing_index] <= TIME_WIDTH'(item.timing_value);
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      grp       <= '0;
      k         <= '0;
      first     <= 1'b1;
      mode      <= ST_VALID;
    end else begin
      // The output register empties when taken, unless a new transaction is loaded into it.
      if (result.ready && !(state == S_EMIT && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc && item.cmd == CMD_COMPUTE) begin
            period <= PER_W'(cp_eff) * PER_W'(PS_PER_NS);
            k      <= '0;
            if (rc_short) begin
              mode  <= ST_EDO;
              state <= S_EMIT;
            end else if (item.check_only) begin
              mode  <= ST_CHECKED;
              state <= S_EMIT;
            end else begin
              mode  <= ST_VALID;
              step  <= '0;
              grp   <= '0;
              first <= 1'b1;
              state <= S_ACC;
            end
          end
        end
        S_ACC: begin
          acc   <= (first || rd > acc) ? rd : acc;
          step  <= step + STEP_W'(1);
          first <= step_ends_group(step);
          if (step_ends_group(step)) begin
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            cyc[grp] <= div_rsp.quotient;
            if (grp == GRP_W'(NUM_GROUPS - 1)) begin
              state <= S_FIN1;
            end else begin
              grp   <= grp + GRP_W'(1);
              state <= S_ACC;
            end
          end
        end
        S_FIN1: begin
          wsetup_r <= (cyc[G_WSETUP] > cyc[G_WPULSE]) ?
                      SUM_W'(cyc[G_WSETUP] - cyc[G_WPULSE]) : '0;
          rsum_r   <= SUM_W'(cyc[G_RHOLD]) + SUM_W'(cyc[G_RPULSE]);
          tdf_r    <= tdf_clamped;
          state    <= S_FIN2;
        end
        S_FIN2: begin
          wsum_r   <= SUM_W'(cyc[G_WPULSE]) + wsetup_r + SUM_W'(cyc[G_WHOLD]);
          rcycle_r <= (rsum_r > SUM_W'(cyc[G_RC])) ? rsum_r : SUM_W'(cyc[G_RC]);
          state    <= S_FIN3;
        end
        S_FIN3: begin
          wcycle_r <= (wsum_r > SUM_W'(cyc[G_WC])) ? wsum_r : SUM_W'(cyc[G_WC]);
          k        <= '0;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_code   <= (mode == ST_VALID) ? k : F_NWE_SETUP;
            out_enc    <= (mode == ST_VALID) ? emit_enc : '0;
            out_status <= mode;
            out_last   <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              k <= k + FIELD_CODE_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.field_code    = out_code;
  assign result.encoded_value = out_enc;
  assign result.status        = out_status;
  assign result.last          = out_last;

  // The shared divider is only started once the previous division has finished.
  ap_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A quotient is only ever delivered while the sequencer is waiting for it.
  ap_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_WAIT)
    else $error("divider result arrived outside the wait state");

  // A status-only result is a lone, final, zero-valued transaction.
  ap_status_single: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_VALID |->
      result.last && result.field_code == F_NWE_SETUP && result.encoded_value == '0)
    else $error("malformed status result");

  // A full run ends on the write-busy field.
  ap_last_field: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last && result.status == ST_VALID |-> result.field_code == F_TWB)
    else $error("compute run ended on the wrong field");

  // TDF never reaches the output as zero.
  ap_tdf_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && mode == ST_VALID |-> tdf_r != '0)
    else $error("TDF count outside its clamp");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the NAND timing to bus cycle converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ntbc_pkg::*;

  // Before a clock period write and at the end of the run we let SETTLE_CYCLES pass, so the
  // block has certainly gone quiet.
  localparam int SETTLE_CYCLES = 400;
  localparam int MAX_REPORTS   = 100;
  localparam int PHASE_ITEMS   = 47;
  localparam logic [TIMING_VALUE_W-1:0] PS_MAX = '1;

  // One input transaction: a timing load or a compute request.
  typedef struct {
    logic                      cmd;
    logic [IDX_W-1:0]          idx;
    logic [TIMING_VALUE_W-1:0] ps;
    logic                      check_only;
  } timing_item_t;

  // One result transaction: an encoded cycle count, or a status on its own.
  typedef struct {
    logic [FIELD_CODE_W-1:0] code;
    logic [ENC_W-1:0]        value;
    logic [STATUS_W-1:0]     status;
    logic                    last;
  } bus_count_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CP_W-1:0] cfg_wr_data;

  ntbc_in_if  item_ch ();
  ntbc_out_if result_ch ();

  nand_timing_to_bus_cycles dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch)
  );

  always #5 clk = ~clk;

  // Our own copy of the block's state: the timing register file and the clock period.
  logic [TIME_WIDTH-1:0] timing_regs [NUM_TIMINGS];
  logic [CP_W-1:0]       period_ns;

  timing_item_t timing_items_pending[$];
  bus_count_t   counts_due[$];
  int           mismatches = 0;

  task automatic report(input string what);
    if (mismatches < MAX_REPORTS) $display("tb: mismatch at %0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic longint unsigned larger(input longint unsigned a, input longint unsigned b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint unsigned period_ps();
    return longint'((period_ns == '0) ? 1 : period_ns) * PS_PER_NS;
  endfunction

  // Picoseconds to clock cycles, rounded up.
  function automatic longint unsigned cycles_for(input longint unsigned ps);
    return (ps + period_ps() - 1) / period_ps();
  endfunction

  // Split encoding: an msb field worth 'weight' above an lsb field of 'pos' bits. An lsb that
  // does not fit rolls over into the msb; an msb that does not fit saturates both fields.
  function automatic logic [ENC_W-1:0] split_code(input longint unsigned n,
                                                  input int unsigned pos,
                                                  input int unsigned width,
                                                  input longint unsigned weight);
    longint unsigned lsb_mask;
    longint unsigned msb_mask;
    longint unsigned msb;
    longint unsigned lsb;
    lsb_mask = (64'd1 << pos) - 1;
    msb_mask = (64'd1 << width) - 1;
    msb = n / weight;
    lsb = n % weight;
    if (lsb > lsb_mask) begin
      lsb = 0;
      msb++;
    end
    if (msb > msb_mask) begin
      msb = msb_mask;
      lsb = lsb_mask;
    end
    return ENC_W'((msb << pos) | lsb);
  endfunction

  function automatic logic [ENC_W-1:0] as_setup(input longint unsigned n);
    return split_code(n, 5, 1, 128);
  endfunction

  function automatic logic [ENC_W-1:0] as_pulse(input longint unsigned n);
    return split_code(n, 6, 1, 256);
  endfunction

  function automatic logic [ENC_W-1:0] as_cycle(input longint unsigned n);
    return split_code(n, 7, 2, 256);
  endfunction

  function automatic logic [ENC_W-1:0] as_timing(input longint unsigned n);
    return split_code(n, 3, 1, 64);
  endfunction

  task automatic push_count(input logic [FIELD_CODE_W-1:0] code, input logic [ENC_W-1:0] value,
                            input logic last);
    counts_due.push_back('{code: code, value: value, status: ST_VALID, last: last});
  endtask

  // Applies one accepted input transaction to our state and queues the results it must cause.
  task automatic predict_counts(input timing_item_t it);
    longint unsigned wpulse, wsetup, whold, wcycle, rhold, rhz, tdf, rpulse, rcycle;
    if (it.cmd == CMD_LOAD) begin
      if (it.idx < NUM_TIMINGS) timing_regs[it.idx] = TIME_WIDTH'(it.ps);
      return;
    end
    // The EDO check wins over check-only.
    if (timing_regs[T_RC] < EDO_LIMIT_PS) begin
      counts_due.push_back('{code: F_NWE_SETUP, value: '0, status: ST_EDO, last: 1'b1});
      return;
    end
    if (it.check_only) begin
      counts_due.push_back('{code: F_NWE_SETUP, value: '0, status: ST_CHECKED, last: 1'b1});
      return;
    end

    wpulse = cycles_for(timing_regs[T_WP]);
    wsetup = cycles_for(larger(larger(timing_regs[T_CLS], timing_regs[T_CS]),
                               larger(timing_regs[T_ALS], timing_regs[T_DS])));
    wsetup = (wsetup > wpulse) ? wsetup - wpulse : 0;
    whold  = cycles_for(larger(larger(larger(timing_regs[T_CLH], timing_regs[T_CH]),
                                      larger(timing_regs[T_ALH], timing_regs[T_DH])),
                               timing_regs[T_WH]));
    wcycle = larger(wpulse + wsetup + whold, cycles_for(timing_regs[T_WC]));

    rhold = cycles_for(larger(timing_regs[T_REH], timing_regs[T_RHOH]));
    rhz   = cycles_for(timing_regs[T_RHZ]);
    // A data float time shorter than the read hold gives 1 rather than wrapping below zero.
    tdf   = (rhz > rhold) ? rhz - rhold : 0;
    if (tdf > TDF_MAX) tdf = TDF_MAX;
    else if (tdf < 1) tdf = 1;
    rpulse = cycles_for(timing_regs[T_RP]);
    rcycle = larger(rhold + rpulse, cycles_for(timing_regs[T_RC]));

    push_count(F_NWE_SETUP, as_setup(wsetup), 1'b0);
    push_count(F_NWE_PULSE, as_pulse(wpulse), 1'b0);
    push_count(F_NWE_CYCLE, as_cycle(wcycle), 1'b0);
    push_count(F_NCS_WR,    as_pulse(wcycle), 1'b0);
    push_count(F_NRD_PULSE, as_pulse(rpulse), 1'b0);
    push_count(F_NRD_CYCLE, as_cycle(rcycle), 1'b0);
    push_count(F_NCS_RD,    as_pulse(rcycle), 1'b0);
    push_count(F_TDF,       ENC_W'(tdf),      1'b0);
    push_count(F_TCLR,      as_timing(cycles_for(timing_regs[T_CLR])), 1'b0);
    push_count(F_TADL,      as_timing(cycles_for(timing_regs[T_ADL])), 1'b0);
    push_count(F_TAR,       as_timing(cycles_for(timing_regs[T_AR])),  1'b0);
    push_count(F_TRR,       as_timing(cycles_for(timing_regs[T_RR])),  1'b0);
    push_count(F_TWB,       as_timing(cycles_for(timing_regs[T_WB])),  1'b1);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Input driver. Items go out in bursts of random length with random gaps between them; the
  // burst length and the gap are drawn afresh at the end of every burst, and about a quarter of
  // the gaps are empty so that long back-to-back stretches occur too. The model is updated at
  // the clock edge at which the transaction is accepted.
  // ---------------------------------------------------------------------------------------------
  timing_item_t on_bus;
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) predict_counts(on_bus);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (timing_items_pending.size() > 0) begin
          on_bus = timing_items_pending.pop_front();
          item_ch.cmd          <= on_bus.cmd;
          item_ch.timing_index <= on_bus.idx;
          item_ch.timing_value <= on_bus.ps;
          item_ch.check_only   <= on_bus.check_only;
          item_ch.valid        <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Result side. Ready follows a 16-bit pattern that is redrawn each time the pattern age wraps
  // to zero; one pattern in four never stalls, and every other one has its lowest bit set. Each
  // accepted result transaction is checked field by field against the oldest expectation.
  // ---------------------------------------------------------------------------------------------
  logic [15:0] ready_pattern = '1;
  logic [3:0]  pattern_pos   = '0;
  logic [5:0]  pattern_age   = '0;

  always @(posedge clk) begin
    if (pattern_age == '0)
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    result_ch.ready <= ready_pattern[pattern_pos];
    pattern_pos++;
    pattern_age++;
  end

  always @(posedge clk) begin
    bus_count_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (counts_due.size() == 0) begin
        report($sformatf("unexpected result, field_code %0d", result_ch.field_code));
      end else begin
        want = counts_due.pop_front();
        if (result_ch.field_code !== want.code)
          report($sformatf("field_code got %0d want %0d", result_ch.field_code, want.code));
        if (result_ch.encoded_value !== want.value)
          report($sformatf("encoded_value for field %0d got %0d want %0d",
                           want.code, result_ch.encoded_value, want.value));
        if (result_ch.status !== want.status)
          report($sformatf("status for field %0d got %0d want %0d",
                           want.code, result_ch.status, want.status));
        if (result_ch.last !== want.last)
          report($sformatf("last for field %0d got %0b want %0b",
                           want.code, result_ch.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------------
  task automatic queue_load(input int idx, input logic [TIMING_VALUE_W-1:0] ps, input logic co);
    timing_items_pending.push_back('{cmd: CMD_LOAD, idx: IDX_W'(idx), ps: ps, check_only: co});
  endtask

  task automatic queue_compute(input logic co);
    timing_items_pending.push_back('{cmd: CMD_COMPUTE, idx: IDX_W'($urandom),
                                     ps: TIMING_VALUE_W'($urandom), check_only: co});
  endtask

  // Timing values of random magnitude, so that every encoding is seen from small counts up to
  // saturation. Some land on or next to a whole number of clock periods, to probe rounding up.
  function automatic logic [TIMING_VALUE_W-1:0] random_ps();
    longint unsigned v;
    int nbits;
    if ($urandom_range(0, 7) == 0) begin
      v = longint'($urandom_range(0, 70)) * period_ps();
      if (v > 0 && $urandom_range(0, 2) == 0) v = v - 1;
      else if ($urandom_range(0, 1) == 0) v = v + 1;
      if (v > PS_MAX) v = PS_MAX;
      return TIMING_VALUE_W'(v);
    end
    nbits = $urandom_range(0, TIMING_VALUE_W);
    return TIMING_VALUE_W'($urandom) & TIMING_VALUE_W'((64'd1 << nbits) - 1);
  endfunction

  // The read cycle time decides between a full compute and an EDO refusal, so it is mostly
  // kept above the limit, with the odd value just either side of it or well below.
  function automatic logic [TIMING_VALUE_W-1:0] random_trc();
    case ($urandom_range(0, 7))
      0:       return random_ps();
      1:       return TIMING_VALUE_W'(EDO_LIMIT_PS - 1 + $urandom_range(0, 1));
      default: return TIMING_VALUE_W'($urandom_range(EDO_LIMIT_PS, PS_MAX));
    endcase
  endfunction

  task automatic queue_random_load(input int idx);
    queue_load(idx, (idx == T_RC) ? random_trc() : random_ps(), 1'($urandom));
  endtask

  // Mostly well-formed sequences: a full or partial set of timings and then a compute. The rest
  // is loads with no compute after them, stray computes and loads to slots that do not exist;
  // the last of these the block ignores, so they are not counted.
  task automatic queue_random_phase(input int n_items);
    int sent;
    int k;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 2) == 0) begin
            for (int i = 0; i < NUM_TIMINGS; i++) queue_random_load(i);
            k = NUM_TIMINGS;
          end else begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) queue_random_load($urandom_range(0, NUM_TIMINGS - 1));
          end
          queue_compute($urandom_range(0, 5) == 0);
          sent += k + 1;
        end
        7: begin
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++) queue_random_load($urandom_range(0, NUM_TIMINGS - 1));
          sent += k;
        end
        8: queue_load($urandom_range(NUM_TIMINGS, 31), TIMING_VALUE_W'($urandom), 1'($urandom));
        default: begin
          queue_compute(1'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  // Waits until every queued transaction has been accepted and every expected result has
  // arrived, then lets the block run on long enough to finish anything that makes no result.
  task automatic wait_quiet();
    while (timing_items_pending.size() != 0 || item_ch.valid || counts_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [CP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    period_ns = v;
  endtask

  // ---------------------------------------------------------------------------------------------
  // Sequence of the run: reset, a directed part at the reset clock period, then random phases
  // at a series of clock periods, the extremes and a zero period among them.
  // ---------------------------------------------------------------------------------------------
  initial begin
    logic [CP_W-1:0] next_period;
    rst                        = 1'b1;
    cfg_wr_en                  = 1'b0;
    cfg_wr_data                = '0;
    item_ch.valid              = 1'b0;
    item_ch.cmd                = CMD_LOAD;
    item_ch.timing_index       = '0;
    item_ch.timing_value       = '0;
    item_ch.check_only         = 1'b0;
    result_ch.ready            = 1'b0;
    period_ns                  = CP_RESET;
    foreach (timing_regs[i]) timing_regs[i] = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // All timings are zero after reset, so both computes are refused as EDO, check-only or not.
    queue_compute(1'b0);
    queue_compute(1'b1);
    // One picosecond short of the EDO limit is still refused; the limit itself passes.
    queue_load(T_RC, TIMING_VALUE_W'(EDO_LIMIT_PS - 1), 1'b1);
    queue_compute(1'b0);
    queue_load(T_RC, TIMING_VALUE_W'(EDO_LIMIT_PS), 1'b1);
    queue_compute(1'b1);
    // Loads to slots beyond the last timing are dropped.
    queue_load(31, PS_MAX, 1'b0);
    queue_load(NUM_TIMINGS, '0, 1'b1);
    // Write pulse at its largest value, setup below the pulse, data float time shorter than read hold.
    queue_load(T_WP, PS_MAX, 1'b0);
    queue_load(T_WB, '0, 1'b0);
    queue_load(T_REH, TIMING_VALUE_W'(50000), 1'b0);
    queue_compute(1'b0);
    // Setup and cycles at their largest timing values, TDF clamped at the top, exact multiples of the period.
    queue_load(T_WP, '0, 1'b0);
    queue_load(T_CLS, PS_MAX, 1'b0);
    queue_load(T_RHZ, PS_MAX, 1'b0);
    queue_load(T_WC, PS_MAX, 1'b0);
    queue_load(T_ADL, TIMING_VALUE_W'(64 * 8000), 1'b0);
    queue_load(T_CLR, TIMING_VALUE_W'(7 * 8000), 1'b0);
    queue_load(T_RC, PS_MAX, 1'b0);
    queue_compute(1'b0);
    wait_quiet();

    queue_random_phase(PHASE_ITEMS);
    for (int p = 0; p < 7; p++) begin
      wait_quiet();
      case (p)
        0:       next_period = CP_W'(1);
        1:       next_period = CP_W'(1000);
        2:       next_period = '0;
        3:       next_period = '1;
        4:       next_period = CP_W'(3);
        5:       next_period = CP_W'($urandom_range(2, 20));
        default: next_period = CP_W'($urandom_range(1, 1000));
      endcase
      write_period(next_period);
      queue_random_phase(PHASE_ITEMS);
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run could take.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
